### src/ldsk_pkg.sv
// Package for the LOOK disk scheduler: sizes, result and command codes,
// register indexes, controller states and the request table entry type.
// Depends on nothing; imported by look_disk_scheduler.
package ldsk_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CYL_BITS    = 16;
  localparam int TIME_BITS   = 32;
  localparam int CFG_BITS    = 1;

  localparam logic [CYL_BITS-1:0] START_CYL_RESET = CYL_BITS'(1);
  localparam logic [CYL_BITS-1:0] MAX_CYL_RESET   = '1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_BITS-1:0] CFG_START_CYL = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] CFG_MAX_CYL   = CFG_BITS'(1);

  typedef enum logic [1:0] {
    RK_ACCEPT = 2'd0,
    RK_REJECT = 2'd1,
    RK_DONE   = 2'd2,
    RK_STATUS = 2'd3
  } result_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_TICK,
    S_SCAN,
    S_PICK,
    S_ZERO,
    S_STEP,
    S_ARRIVE,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic [CYL_BITS-1:0]  cyl;
    logic [TIME_BITS-1:0] arr;
  } entry_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] slot;
    logic [CYL_BITS-1:0]  span;
    logic [CYL_BITS-1:0]  cyl;
    logic [TIME_BITS-1:0] arr;
  } cand_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [SLOT_BITS-1:0] slot;
    logic [CYL_BITS-1:0]  cyl;
    logic [TIME_BITS-1:0] wait_ticks;
    logic [CYL_BITS-1:0]  head;
    logic [TIME_BITS-1:0] now;
    logic                 last;
  } result_t;

endpackage

### src/look_disk_scheduler.sv
// LOOK elevator disk scheduler top level: request table memory, scan controller
// and result register. Depends on ldsk_pkg.
//
//   channel   signals                          direction   transaction
//   cmd       cmd_valid / cmd_stall            in          one add or one tick
//   result    result_valid / result_stall      out         one result, last marks the end
//   config    cfg_we, cfg_index, cfg_data      in          one register write
//
// An add returns one result. A tick runs a selection round while the head is idle and the
// table holds requests, the scan reading one slot a cycle from the single read port of the
// request memory. Each zero-distance completion starts another round.
// Reset is synchronous; the memory is not cleared, the slot valid bits are.
// A stalled result holds the controller in its emitting state; a new command is
// taken while the last result of the previous one still waits.
module look_disk_scheduler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ldsk_pkg::CFG_BITS-1:0]        cfg_index,
  input  logic [ldsk_pkg::CYL_BITS-1:0]        cfg_data,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic                                 cmd,
  input  logic [ldsk_pkg::CYL_BITS-1:0]        req_cylinder,
  input  logic [ldsk_pkg::TIME_BITS-1:0]       arrival_time,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ldsk_pkg::result_kind_t               result_kind,
  output logic [ldsk_pkg::SLOT_BITS-1:0]       slot,
  output logic [ldsk_pkg::CYL_BITS-1:0]        done_cylinder,
  output logic [ldsk_pkg::TIME_BITS-1:0]       wait_ticks,
  output logic [ldsk_pkg::CYL_BITS-1:0]        head_position,
  output logic [ldsk_pkg::TIME_BITS-1:0]       now_time,
  output logic                                 last
);
  import ldsk_pkg::*;

  state_t                 state, state_next;
  logic [CYL_BITS-1:0]    max_cylinder, head_cyl, target_cyl, head_step;
  logic                   moving_up, busy;
  logic [SLOT_BITS-1:0]   target_slot;
  logic [TIME_BITS-1:0]   target_wait, clock_time;
  logic [QUEUE_DEPTH-1:0] slot_valid;

  entry_t                 mem [QUEUE_DEPTH];
  entry_t                 rd_entry;
  logic [SLOT_BITS-1:0]   rd_addr;
  logic                   mem_we;

  logic                   req_cmd;
  logic [CYL_BITS-1:0]    req_cyl;
  logic [TIME_BITS-1:0]   req_arr;

  logic [SLOT_BITS:0]     scan_cnt;
  logic                   scan_end;
  logic                   eval_en;
  logic [SLOT_BITS-1:0]   eval_idx;
  logic                   ev_ok, up_upd, dn_upd;
  logic [CYL_BITS-1:0]    up_d, dn_d;
  cand_t                  up_best, dn_best, sel;
  logic                   cur_found;

  logic                   free_found, add_ok;
  logic [SLOT_BITS-1:0]   free_slot;

  logic                   out_free, out_load;
  result_t                out_q, out_next;

  assign rd_addr  = scan_cnt[SLOT_BITS-1:0];
  assign scan_end = (scan_cnt == (SLOT_BITS+1)'(QUEUE_DEPTH));
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_BITS'(i);
      end
    end
  end

  assign add_ok = (req_cyl <= max_cylinder) && free_found;

  always_comb begin
    ev_ok  = eval_en && slot_valid[eval_idx] && (rd_entry.arr <= clock_time);
    up_d   = rd_entry.cyl - head_cyl;
    dn_d   = head_cyl - rd_entry.cyl;
    up_upd = ev_ok && (rd_entry.cyl >= head_cyl) && (!up_best.found || up_d <= up_best.span);
    dn_upd = ev_ok && (rd_entry.cyl <= head_cyl) && (!dn_best.found || dn_d <= dn_best.span);
  end

  assign cur_found = moving_up ? up_best.found : dn_best.found;
  assign sel       = (moving_up == cur_found) ? up_best : dn_best;

  always_comb begin
    if (target_cyl > head_cyl) begin
      head_step = head_cyl + CYL_BITS'(1);
    end else if (target_cyl < head_cyl) begin
      head_step = head_cyl - CYL_BITS'(1);
    end else begin
      head_step = head_cyl;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd == CMD_ADD) ? S_ADD : S_TICK;
        end
      end
      S_ADD: begin
        if (out_free) state_next = S_IDLE;
      end
      S_TICK: begin
        state_next = (busy || slot_valid == '0) ? S_STEP : S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_next = S_PICK;
      end
      S_PICK: begin
        state_next = (sel.found && sel.span == '0) ? S_ZERO : S_STEP;
      end
      S_ZERO: begin
        if (out_free) state_next = S_TICK;
      end
      S_STEP: begin
        state_next = (busy && head_step == target_cyl) ? S_ARRIVE : S_STATUS;
      end
      S_ARRIVE: begin
        if (out_free) state_next = S_STATUS;
      end
      S_STATUS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall           = (state != S_IDLE);
    mem_we              = 1'b0;
    out_load            = 1'b0;
    out_next            = '0;
    out_next.kind       = RK_STATUS;
    out_next.head       = head_cyl;
    out_next.now        = clock_time;
    case (state)
      S_ADD: begin
        mem_we        = out_free && add_ok;
        out_load      = out_free;
        out_next.kind = add_ok ? RK_ACCEPT : RK_REJECT;
        out_next.slot = add_ok ? free_slot : '0;
        out_next.last = 1'b1;
      end
      S_ZERO, S_ARRIVE: begin
        out_load            = out_free;
        out_next.kind       = RK_DONE;
        out_next.slot       = target_slot;
        out_next.cyl        = target_cyl;
        out_next.wait_ticks = target_wait;
      end
      S_STATUS: begin
        out_load      = out_free;
        out_next.kind = RK_STATUS;
        out_next.slot = busy ? target_slot : '0;
        out_next.now  = clock_time + TIME_BITS'(1);
        out_next.last = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_slot] <= '{cyl: req_cyl, arr: req_arr};
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      req_cmd <= cmd;
      req_cyl <= req_cylinder;
      req_arr <= arrival_time;
    end
    if (state == S_PICK && sel.found) begin
      target_cyl <= sel.cyl;
    end
    eval_idx <= rd_addr;
    if (out_load) begin
      out_q <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      head_cyl      <= START_CYL_RESET;
      max_cylinder  <= MAX_CYL_RESET;
      moving_up     <= 1'b1;
      busy          <= 1'b0;
      target_slot   <= '0;
      target_wait   <= '0;
      clock_time    <= '0;
      scan_cnt      <= '0;
      eval_en       <= 1'b0;
      up_best.found <= 1'b0;
      dn_best.found <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      eval_en <= (state == S_SCAN) && !scan_end;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_CYL: head_cyl <= cfg_data;
          CFG_MAX_CYL:   max_cylinder <= cfg_data;
          default:       max_cylinder <= max_cylinder;
        endcase
      end
      if (up_upd) begin
        up_best.found <= 1'b1;
        up_best.slot  <= eval_idx;
        up_best.span  <= up_d;
        up_best.cyl   <= rd_entry.cyl;
        up_best.arr   <= rd_entry.arr;
      end
      if (dn_upd) begin
        dn_best.found <= 1'b1;
        dn_best.slot  <= eval_idx;
        dn_best.span  <= dn_d;
        dn_best.cyl   <= rd_entry.cyl;
        dn_best.arr   <= rd_entry.arr;
      end
      case (state)
        S_ADD: begin
          if (mem_we) slot_valid[free_slot] <= 1'b1;
        end
        S_TICK: begin
          scan_cnt      <= '0;
          up_best.found <= 1'b0;
          dn_best.found <= 1'b0;
        end
        S_SCAN: begin
          if (!scan_end) scan_cnt <= scan_cnt + (SLOT_BITS+1)'(1);
        end
        S_PICK: begin
          if (!cur_found) moving_up <= !moving_up;
          if (sel.found) begin
            target_slot <= sel.slot;
            target_wait <= clock_time - sel.arr;
            busy        <= (sel.span != '0);
          end
        end
        S_ZERO: begin
          if (out_free) slot_valid[target_slot] <= 1'b0;
        end
        S_STEP: begin
          if (busy) head_cyl <= head_step;
        end
        S_ARRIVE: begin
          if (out_free) begin
            slot_valid[target_slot] <= 1'b0;
            busy                    <= 1'b0;
          end
        end
        S_STATUS: begin
          if (out_free) clock_time <= clock_time + TIME_BITS'(1);
        end
        default: busy <= busy;
      endcase
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign result_kind   = out_q.kind;
  assign slot          = out_q.slot;
  assign done_cylinder = out_q.cyl;
  assign wait_ticks    = out_q.wait_ticks;
  assign head_position = out_q.head;
  assign now_time      = out_q.now;
  assign last          = out_q.last;

  a_busy_target_valid: assert property (@(posedge clk) disable iff (rst)
    busy |-> slot_valid[target_slot])
    else $error("The head is busy with a slot that holds no request.");

  a_scan_only_idle_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !busy)
    else $error("A table scan runs while a request is in service.");

  a_load_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(result_valid && result_stall))
    else $error("A result overwrote a stalled transaction.");

  a_add_on_add_cmd: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (req_cmd == CMD_ADD) && !slot_valid[free_slot])
    else $error("The request table was written outside an add or into a used slot.");

endmodule

### test/look_disk_scheduler_check.sv
`timescale 1ns / 1ps
// Checker for the LOOK disk scheduler: watches the command, result and register
// write ports, keeps its own model of the request table and head, and compares
// every result transaction field by field. Depends on ldsk_pkg.
module look_disk_scheduler_check
  import ldsk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_index,
  input  logic [CYL_BITS-1:0]   cfg_data,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  logic                  cmd,
  input  logic [CYL_BITS-1:0]   req_cylinder,
  input  logic [TIME_BITS-1:0]  arrival_time,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_kind_t          result_kind,
  input  logic [SLOT_BITS-1:0]  slot,
  input  logic [CYL_BITS-1:0]   done_cylinder,
  input  logic [TIME_BITS-1:0]  wait_ticks,
  input  logic [CYL_BITS-1:0]   head_position,
  input  logic [TIME_BITS-1:0]  now_time,
  input  logic                  last,
  input  logic                  finish_check,
  output int                    fail_count,
  output int                    live_requests,
  output int                    results_pending
);

  logic                 slot_used [QUEUE_DEPTH];
  logic [CYL_BITS-1:0]  slot_cyl [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_arr [QUEUE_DEPTH];
  logic [CYL_BITS-1:0]  head;
  logic [CYL_BITS-1:0]  max_cyl;
  logic                 sweep_up;
  logic                 seeking;
  logic [SLOT_BITS-1:0] target;
  logic [TIME_BITS-1:0] target_wait;
  logic [TIME_BITS-1:0] clock_now;
  result_t              expected_results [$];
  int                   failures = 0;

  function automatic int nearest_slot(logic up);
    int best;
    logic [CYL_BITS-1:0] best_d;
    logic [CYL_BITS-1:0] d;
    logic ahead;
    best = -1;
    best_d = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ahead = up ? (slot_cyl[i] >= head) : (slot_cyl[i] <= head);
      d = up ? slot_cyl[i] - head : head - slot_cyl[i];
      if (slot_used[i] && slot_arr[i] <= clock_now && ahead && (best < 0 || d <= best_d)) begin
        best = i;
        best_d = d;
      end
    end
    return best;
  endfunction

  function automatic logic table_occupied();
    logic any;
    any = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) any |= slot_used[i];
    return any;
  endfunction

  // Requests with the top arrival bit set never become eligible.
  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i] && !slot_arr[i][TIME_BITS-1]) n++;
    return n;
  endfunction

  task automatic queue_result(result_kind_t k, int s, logic [CYL_BITS-1:0] c,
                              logic [TIME_BITS-1:0] w, logic l);
    result_t r;
    r.kind = k;
    r.slot = s[SLOT_BITS-1:0];
    r.cyl = c;
    r.wait_ticks = w;
    r.head = head;
    r.now = clock_now;
    r.last = l;
    expected_results.push_back(r);
  endtask

  task automatic predict_add(logic [CYL_BITS-1:0] c, logic [TIME_BITS-1:0] a);
    int free_slot;
    free_slot = -1;
    if (c <= max_cyl)
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (!slot_used[i] && free_slot < 0) free_slot = i;
    if (free_slot < 0) begin
      queue_result(RK_REJECT, 0, '0, '0, 1'b1);
    end else begin
      slot_used[free_slot] = 1'b1;
      slot_cyl[free_slot] = c;
      slot_arr[free_slot] = a;
      queue_result(RK_ACCEPT, free_slot, '0, '0, 1'b1);
    end
  endtask

  task automatic predict_tick();
    int s;
    logic stuck;
    stuck = 1'b0;
    while (!seeking && !stuck && table_occupied()) begin
      s = nearest_slot(sweep_up);
      if (s < 0) begin
        sweep_up = !sweep_up;
        s = nearest_slot(sweep_up);
      end
      if (s < 0) begin
        stuck = 1'b1;
      end else begin
        seeking = 1'b1;
        target = s[SLOT_BITS-1:0];
        target_wait = clock_now - slot_arr[s];
        if (slot_cyl[s] == head) begin
          slot_used[s] = 1'b0;
          seeking = 1'b0;
          queue_result(RK_DONE, s, slot_cyl[s], target_wait, 1'b0);
        end
      end
    end
    if (seeking) begin
      if (slot_cyl[target] > head) head++;
      else if (slot_cyl[target] < head) head--;
      if (slot_cyl[target] == head) begin
        slot_used[target] = 1'b0;
        seeking = 1'b0;
        queue_result(RK_DONE, int'(target), slot_cyl[target], target_wait, 1'b0);
      end
    end
    clock_now++;
    queue_result(RK_STATUS, seeking ? int'(target) : 0, '0, '0, 1'b1);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin : watch
    result_t e;
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_cyl[i] = '0;
        slot_arr[i] = '0;
      end
      head = START_CYL_RESET;
      max_cyl = MAX_CYL_RESET;
      sweep_up = 1'b1;
      seeking = 1'b0;
      target = '0;
      target_wait = '0;
      clock_now = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_CYL) head = cfg_data;
        else if (cfg_index == CFG_MAX_CYL) max_cyl = cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(result_kind), 32'(0));
        end else begin
          e = expected_results.pop_front();
          if (result_kind !== e.kind) report_mismatch("result_kind", 32'(result_kind), 32'(e.kind));
          if (slot !== e.slot) report_mismatch("slot", 32'(slot), 32'(e.slot));
          if (done_cylinder !== e.cyl) report_mismatch("done_cylinder", 32'(done_cylinder), 32'(e.cyl));
          if (wait_ticks !== e.wait_ticks) report_mismatch("wait_ticks", wait_ticks, e.wait_ticks);
          if (head_position !== e.head) report_mismatch("head_position", 32'(head_position), 32'(e.head));
          if (now_time !== e.now) report_mismatch("now_time", now_time, e.now);
          if (last !== e.last) report_mismatch("last", 32'(last), 32'(e.last));
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (cmd == CMD_ADD) predict_add(req_cylinder, arrival_time);
        else predict_tick();
      end
      if (finish_check && expected_results.size() != 0)
        report_mismatch("results still expected", 32'(expected_results.size()), 32'(0));
    end
    fail_count <= failures;
    live_requests <= live_count();
    results_pending <= expected_results.size();
  end

endmodule

### test/look_disk_scheduler_test.sv
`timescale 1ns / 1ps
// Top of the LOOK disk scheduler testbench: clock, reset, register settings and
// command stimulus with random idling; the verdict comes from the checker's count.
// Depends on ldsk_pkg, look_disk_scheduler and look_disk_scheduler_check.
module look_disk_scheduler_test;
  import ldsk_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_BITS-1:0]   cfg_index = '0;
  logic [CYL_BITS-1:0]   cfg_data = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  logic                  cmd = CMD_ADD;
  logic [CYL_BITS-1:0]   req_cylinder = '0;
  logic [TIME_BITS-1:0]  arrival_time = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_kind_t          result_kind;
  logic [SLOT_BITS-1:0]  slot;
  logic [CYL_BITS-1:0]   done_cylinder;
  logic [TIME_BITS-1:0]  wait_ticks;
  logic [CYL_BITS-1:0]   head_position;
  logic [TIME_BITS-1:0]  now_time;
  logic                  last;
  logic                  finish_check = 1'b0;
  int                    fail_count;
  int                    live_requests;
  int                    results_pending;

  logic                  quiet = 1'b0;
  int                    stall_left = 0;
  int                    idle_cycles = 0;
  logic [TIME_BITS-1:0]  ticks_sent = '0;
  int                    far_left = 1;

  look_disk_scheduler i_dut (.*);

  look_disk_scheduler_check i_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 6);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (result_valid && !result_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL look_disk_scheduler");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic c, logic [CYL_BITS-1:0] rc, logic [TIME_BITS-1:0] at);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    req_cylinder <= rc;
    arrival_time <= at;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (c == CMD_TICK) ticks_sent++;
  endtask

  task automatic add_request(logic [CYL_BITS-1:0] c, logic [TIME_BITS-1:0] a);
    send_item(CMD_ADD, c, a);
  endtask

  task automatic tick_once();
    send_item(CMD_TICK, CYL_BITS'($urandom), $urandom);
  endtask

  task automatic set_config(logic [CYL_BITS-1:0] start_cyl, logic [CYL_BITS-1:0] max_cyl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_CYL;
    cfg_data <= start_cyl;
    @(posedge clk);
    cfg_index <= CFG_MAX_CYL;
    cfg_data <= max_cyl;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Serve every request that can still arrive, so that the next setting
  // starts from an empty table apart from requests that never arrive.
  task automatic settle();
    wait_drained();
    while (live_requests != 0) tick_once();
    wait_drained();
  endtask

  task automatic random_items(int lo, int hi, int max_cyl, int count);
    int burst;
    int r;
    logic [CYL_BITS-1:0] c;
    logic [TIME_BITS-1:0] a;
    burst = 0;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (burst == 0 && r < 5) burst = $urandom_range(6, 18);
      if (burst != 0 || r < 45) begin
        if (burst != 0) burst--;
        r = $urandom_range(0, 99);
        if (r < 8 && max_cyl < 65535) c = CYL_BITS'($urandom_range(max_cyl + 1, 65535));
        else c = CYL_BITS'($urandom_range(lo, hi));
        r = $urandom_range(0, 99);
        if (r < 2 && far_left != 0) begin
          a = {1'b1, 31'($urandom)};
          far_left--;
        end else if (r < 25) begin
          a = $urandom_range(0, ticks_sent);
        end else begin
          a = ticks_sent + $urandom_range(0, 12);
        end
        add_request(c, a);
      end else begin
        tick_once();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_config(16'd0, 16'hFFFF);
    tick_once();
    add_request(16'd0, 32'd0);
    tick_once();
    add_request(16'd5, 32'd0);
    add_request(16'd5, 32'd0);
    add_request(16'd3, ticks_sent + 32'd2);
    repeat (5) tick_once();
    add_request(16'd2, ticks_sent);
    add_request(16'd7, 32'hFFFF_FFFF);
    repeat (4) tick_once();
    random_items(0, 60, 65535, 50);
    settle();

    set_config(16'hFFFF, 16'hFFFF);
    add_request(16'hFFFF, 32'd0);
    tick_once();
    add_request(16'hFFFE, ticks_sent);
    tick_once();
    random_items(65472, 65535, 65535, 50);
    settle();

    set_config(16'd1000, 16'd1100);
    random_items(950, 1150, 1100, 50);
    settle();

    set_config(16'd30000, 16'd30000);
    random_items(29900, 30100, 30000, 50);
    settle();

    quiet <= 1'b1;
    set_config(16'd5, 16'd1);
    add_request(16'hFFFF, ticks_sent);
    add_request(16'd1, ticks_sent);
    add_request(16'd0, 32'd0);
    tick_once();
    random_items(0, 8, 1, 50);
    settle();

    repeat (50) @(posedge clk);
    finish_check <= 1'b1;
    @(posedge clk);
    finish_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS look_disk_scheduler");
    end else begin
      $display("FAIL look_disk_scheduler");
    end
    $finish;
  end

endmodule
